// File: design/mand_pkg.sv
// Shared types, constants and helpers for the escape-time pixel evaluator.
package mand_pkg;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_MAX_ITER     = 3'd0,
        REG_ESCAPE_LIMIT = 3'd1,
        REG_RE_ORIGIN    = 3'd2,
        REG_RE_STEP      = 3'd3,
        REG_IM_ORIGIN    = 3'd4,
        REG_IM_STEP      = 3'd5
    } cfg_reg_t;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int WORD_WIDTH      = 32;
    localparam int ESC_WIDTH       = 7;
    localparam int PEN_WIDTH       = 16;

    // Parameter defaults
    localparam int DEF_COORD_WIDTH = 12;
    localparam int DEF_FRAC_BITS   = 24;
    localparam int DEF_ITER_WIDTH  = 8;

    // Register reset values
    localparam int MAX_ITER_RST                        = 100;
    localparam logic [ESC_WIDTH-1:0] ESC_LIMIT_RST     = 7'd100;
    localparam logic signed [WORD_WIDTH-1:0] RE_ORIGIN_RST = -32'sd36909875;
    localparam logic signed [WORD_WIDTH-1:0] RE_STEP_RST   = 32'sd78643;
    localparam logic signed [WORD_WIDTH-1:0] IM_ORIGIN_RST = -32'sd25165824;
    localparam logic signed [WORD_WIDTH-1:0] IM_STEP_RST   = 32'sd104858;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COORD_RE,
        ST_COORD_IM,
        ST_INIT,
        ST_SQ_X,
        ST_SQ_Y,
        ST_MUL_XY,
        ST_UPDATE,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;    // latch pixel coordinates
        logic coord_re;  // col * re_step
        logic coord_im;  // cx add, row * im_step
        logic init;      // cy add, z = c, n = 1
        logic sq_x;      // x * x
        logic sq_y;      // y * y
        logic mul_xy;    // x * y and x*x - y*y
        logic step_n;    // n = n + 1
        logic update;    // z = z*z + c
        logic load_out;  // result into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic escaped;    // |z|^2 above limit
        logic last_iter;  // n + 1 reaches max_iter
        logic short_run;  // max_iter <= 1, no update at all
        logic out_free;   // output register can take a result
    } status_t;

    function automatic logic signed [WORD_WIDTH-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi)
            sat32 = 32'sh7FFF_FFFF;
        else if (v < lo)
            sat32 = 32'sh8000_0000;
        else
            sat32 = v[WORD_WIDTH-1:0];
    endfunction

    // Pen color from the count; overlapping bit fields are ORed
    function automatic logic [PEN_WIDTH-1:0] pen_colour(input logic [15:0] n);
        logic [PEN_WIDTH-1:0] lo_part;
        logic [PEN_WIDTH-1:0] mid_part;
        logic [PEN_WIDTH-1:0] hi_part;
        lo_part  = {11'd0, n[7:3]};
        mid_part = {5'd0, n[5:0], 5'd0};
        hi_part  = {2'd0, n[3:0], 10'd0};
        pen_colour = lo_part | mid_part | hi_part;
    endfunction

endpackage

// File: design/mand_ctrl.sv
// Sequencing state machine for the escape-time evaluator.
module mand_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  mand_pkg::status_t status,
    output mand_pkg::cmd_t    cmd
);
    import mand_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_COORD_RE;
            end
            ST_COORD_RE: state_next = ST_COORD_IM;
            ST_COORD_IM: state_next = ST_INIT;
            ST_INIT:
            begin
                if (status.short_run)
                    state_next = ST_DONE;
                else
                    state_next = ST_SQ_X;
            end
            ST_SQ_X: state_next = ST_SQ_Y;
            ST_SQ_Y: state_next = ST_MUL_XY;
            ST_MUL_XY:
            begin
                if (status.escaped || status.last_iter)
                    state_next = ST_DONE;
                else
                    state_next = ST_UPDATE;
            end
            ST_UPDATE: state_next = ST_SQ_X;
            ST_DONE:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_COORD_RE: cmd.coord_re = 1'b1;
            ST_COORD_IM: cmd.coord_im = 1'b1;
            ST_INIT:     cmd.init     = 1'b1;
            ST_SQ_X:     cmd.sq_x     = 1'b1;
            ST_SQ_Y:     cmd.sq_y     = 1'b1;
            ST_MUL_XY:
            begin
                cmd.mul_xy = 1'b1;
                cmd.step_n = !status.escaped;
            end
            ST_UPDATE:   cmd.update   = 1'b1;
            ST_DONE:     cmd.load_out = status.out_free;
            default:     cmd          = '0;
        endcase
    end

endmodule

// File: design/mand_dp.sv
// Datapath: shared multiplier, point and orbit registers, result register.
module mand_dp #(
    parameter int COORD_WIDTH = mand_pkg::DEF_COORD_WIDTH,
    parameter int FRAC_BITS   = mand_pkg::DEF_FRAC_BITS,
    parameter int ITER_WIDTH  = mand_pkg::DEF_ITER_WIDTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  mand_pkg::cmd_t                         cmd,
    output mand_pkg::status_t                      status,
    input  logic [COORD_WIDTH-1:0]                 in_col,
    input  logic [COORD_WIDTH-1:0]                 in_row,
    input  logic [ITER_WIDTH-1:0]                  max_iter,
    input  logic [mand_pkg::ESC_WIDTH-1:0]         escape_limit,
    input  logic signed [mand_pkg::WORD_WIDTH-1:0] re_origin,
    input  logic signed [mand_pkg::WORD_WIDTH-1:0] re_step,
    input  logic signed [mand_pkg::WORD_WIDTH-1:0] im_origin,
    input  logic signed [mand_pkg::WORD_WIDTH-1:0] im_step,
    input  logic                                   out_ready,
    output logic                                   out_valid,
    output logic [COORD_WIDTH-1:0]                 out_col,
    output logic [COORD_WIDTH-1:0]                 out_row,
    output logic [ITER_WIDTH-1:0]                  out_iter,
    output logic [mand_pkg::PEN_WIDTH-1:0]         out_pen
);
    import mand_pkg::*;

    localparam int OPW = WORD_WIDTH + 1;

    logic [COORD_WIDTH-1:0]        col_reg;
    logic [COORD_WIDTH-1:0]        row_reg;
    logic signed [63:0]            pxx_reg;
    logic signed [63:0]            pyy_reg;
    logic signed [63:0]            pxy_reg;
    logic signed [63:0]            diff_reg;
    logic signed [WORD_WIDTH-1:0]  x_reg;
    logic signed [WORD_WIDTH-1:0]  y_reg;
    logic signed [WORD_WIDTH-1:0]  cx_reg;
    logic signed [WORD_WIDTH-1:0]  cy_reg;
    logic [ITER_WIDTH-1:0]         n_reg;
    logic                          out_valid_reg;
    logic [COORD_WIDTH-1:0]        out_col_reg;
    logic [COORD_WIDTH-1:0]        out_row_reg;
    logic [ITER_WIDTH-1:0]         out_iter_reg;
    logic [PEN_WIDTH-1:0]          out_pen_reg;

    logic signed [OPW-1:0]         mul_a;
    logic signed [OPW-1:0]         mul_b;
    logic signed [2*OPW-1:0]       mul_p;
    logic signed [63:0]            prod;
    logic signed [63:0]            cx_wide;
    logic signed [63:0]            cy_wide;
    logic signed [63:0]            nx_wide;
    logic signed [63:0]            ny_wide;
    logic [63:0]                   mag_sum;
    logic [63:0]                   limit;
    logic [ITER_WIDTH:0]           n_plus;

    // Shared multiplier, operands chosen by the current step
    always_comb
    begin
        if (cmd.coord_re)
        begin
            mul_a = $signed({{(OPW-COORD_WIDTH){1'b0}}, col_reg});
            mul_b = $signed({re_step[WORD_WIDTH-1], re_step});
        end
        else if (cmd.coord_im)
        begin
            mul_a = $signed({{(OPW-COORD_WIDTH){1'b0}}, row_reg});
            mul_b = $signed({im_step[WORD_WIDTH-1], im_step});
        end
        else if (cmd.sq_x)
        begin
            mul_a = $signed({x_reg[WORD_WIDTH-1], x_reg});
            mul_b = $signed({x_reg[WORD_WIDTH-1], x_reg});
        end
        else if (cmd.sq_y)
        begin
            mul_a = $signed({y_reg[WORD_WIDTH-1], y_reg});
            mul_b = $signed({y_reg[WORD_WIDTH-1], y_reg});
        end
        else
        begin
            mul_a = $signed({x_reg[WORD_WIDTH-1], x_reg});
            mul_b = $signed({y_reg[WORD_WIDTH-1], y_reg});
        end
    end

    assign mul_p = mul_a * mul_b;
    assign prod  = mul_p[63:0];

    // Point: origin plus product held in pxx_reg
    assign cx_wide = $signed({{32{re_origin[WORD_WIDTH-1]}}, re_origin}) + pxx_reg;
    assign cy_wide = $signed({{32{im_origin[WORD_WIDTH-1]}}, im_origin}) + pxx_reg;

    // Orbit update, arithmetic shifts round toward minus infinity
    assign nx_wide = (diff_reg >>> FRAC_BITS) + $signed({{32{cx_reg[WORD_WIDTH-1]}}, cx_reg});
    assign ny_wide = (pxy_reg >>> (FRAC_BITS - 1))
                   + $signed({{32{cy_reg[WORD_WIDTH-1]}}, cy_reg});

    // Squares are never negative, so their sum fits 64 unsigned bits
    assign mag_sum = $unsigned(pxx_reg) + $unsigned(pyy_reg);
    assign limit   = {{(64-ESC_WIDTH){1'b0}}, escape_limit} << (2 * FRAC_BITS);
    assign n_plus  = {1'b0, n_reg} + {{ITER_WIDTH{1'b0}}, 1'b1};

    assign status.escaped   = mag_sum > limit;
    assign status.last_iter = n_plus >= {1'b0, max_iter};
    assign status.short_run = max_iter <= {{(ITER_WIDTH-1){1'b0}}, 1'b1};
    assign status.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            col_reg <= in_col;
            row_reg <= in_row;
        end
        if (cmd.coord_re || cmd.coord_im || cmd.sq_x)
            pxx_reg <= prod;
        if (cmd.coord_im)
            cx_reg <= sat32(cx_wide);
        if (cmd.init)
        begin
            cy_reg <= sat32(cy_wide);
            y_reg  <= sat32(cy_wide);
            x_reg  <= cx_reg;
        end
        if (cmd.sq_y)
            pyy_reg <= prod;
        if (cmd.mul_xy)
        begin
            pxy_reg  <= prod;
            diff_reg <= pxx_reg - pyy_reg;
        end
        if (cmd.update)
        begin
            x_reg <= sat32(nx_wide);
            y_reg <= sat32(ny_wide);
        end
        if (cmd.init)
            n_reg <= {{(ITER_WIDTH-1){1'b0}}, 1'b1};
        else if (cmd.step_n)
            n_reg <= n_plus[ITER_WIDTH-1:0];
        if (cmd.load_out)
        begin
            out_col_reg  <= col_reg;
            out_row_reg  <= row_reg;
            out_iter_reg <= n_reg;
            out_pen_reg  <= pen_colour(16'(n_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;
    assign out_col   = out_col_reg;
    assign out_row   = out_row_reg;
    assign out_iter  = out_iter_reg;
    assign out_pen   = out_pen_reg;

endmodule

// File: design/mandelbrot_escape_time_pixel.sv
// Top level of the escape-time pixel evaluator: ports, register file, assembly.
//
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  s_tdata: col, row
// m_*       out        m_tvalid / m_tready  m_tdata: pixel_col, pixel_row, iter_count, pen_colour
// cfg_*     in         cfg_we               cfg_index, cfg_data (no read-back)
//
// The point is formed in coord_re, coord_im and init; each iteration then runs x*x, y*y
// and x*y on one shared 33x33 multiplier, then the update. A run ends when the point
// escapes or the count runs out, or straight after init when max_iter <= 1;
// the next pixel transfer can come in the cycle after the result is loaded.
// Reset clears the state machine and the output valid, and loads register defaults.
// Stalls: a result waits in the output register; the next one holds input closed until then.
module mandelbrot_escape_time_pixel #(
    parameter int COORD_WIDTH = mand_pkg::DEF_COORD_WIDTH,
    parameter int FRAC_BITS   = mand_pkg::DEF_FRAC_BITS,
    parameter int ITER_WIDTH  = mand_pkg::DEF_ITER_WIDTH
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    // Input pixel
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // col, row; zero padded to whole bytes
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]        s_tdata,
    // Result
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // pixel_col, pixel_row, iter_count, pen_colour; zero padded to whole bytes
    output logic [((2*COORD_WIDTH+ITER_WIDTH+16+7)/8)*8-1:0] m_tdata,
    // Configuration writes
    input  logic                                      cfg_we,
    input  logic [mand_pkg::CFG_INDEX_WIDTH-1:0]      cfg_index,
    input  logic [mand_pkg::CFG_DATA_WIDTH-1:0]       cfg_data
);
    import mand_pkg::*;

    localparam int M_BITS = 2*COORD_WIDTH + ITER_WIDTH + PEN_WIDTH;
    localparam int M_W    = ((M_BITS+7)/8)*8;

    logic [ITER_WIDTH-1:0]         max_iter_reg;
    logic [ESC_WIDTH-1:0]          escape_limit_reg;
    logic signed [WORD_WIDTH-1:0]  re_origin_reg;
    logic signed [WORD_WIDTH-1:0]  re_step_reg;
    logic signed [WORD_WIDTH-1:0]  im_origin_reg;
    logic signed [WORD_WIDTH-1:0]  im_step_reg;

    cmd_t                          cmd;
    status_t                       status;
    logic [COORD_WIDTH-1:0]        out_col;
    logic [COORD_WIDTH-1:0]        out_row;
    logic [ITER_WIDTH-1:0]         out_iter;
    logic [PEN_WIDTH-1:0]          out_pen;

    // Register file; writes beyond the last index are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg     <= ITER_WIDTH'(MAX_ITER_RST);
            escape_limit_reg <= ESC_LIMIT_RST;
            re_origin_reg    <= RE_ORIGIN_RST;
            re_step_reg      <= RE_STEP_RST;
            im_origin_reg    <= IM_ORIGIN_RST;
            im_step_reg      <= IM_STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_ITER:     max_iter_reg     <= cfg_data[ITER_WIDTH-1:0];
                REG_ESCAPE_LIMIT: escape_limit_reg <= cfg_data[ESC_WIDTH-1:0];
                REG_RE_ORIGIN:    re_origin_reg    <= $signed(cfg_data[WORD_WIDTH-1:0]);
                REG_RE_STEP:      re_step_reg      <= $signed(cfg_data[WORD_WIDTH-1:0]);
                REG_IM_ORIGIN:    im_origin_reg    <= $signed(cfg_data[WORD_WIDTH-1:0]);
                REG_IM_STEP:      im_step_reg      <= $signed(cfg_data[WORD_WIDTH-1:0]);
                default:          ;
            endcase
        end
    end

    mand_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mand_dp #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .ITER_WIDTH  (ITER_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_col       (s_tdata[COORD_WIDTH-1:0]),
        .in_row       (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .max_iter     (max_iter_reg),
        .escape_limit (escape_limit_reg),
        .re_origin    (re_origin_reg),
        .re_step      (re_step_reg),
        .im_origin    (im_origin_reg),
        .im_step      (im_step_reg),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_col      (out_col),
        .out_row      (out_row),
        .out_iter     (out_iter),
        .out_pen      (out_pen)
    );

    // Pack result, first field in the low bits
    assign m_tdata = M_W'({out_pen, out_iter, out_row, out_col});

    // One pixel in flight: after an input transfer the port stays closed
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a pixel is in flight");

    // Count is at least one and never passes max_iter (or is one for a short run)
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_iter != '0) &&
                     ((out_iter <= max_iter_reg) || (out_iter == ITER_WIDTH'(1))))
        else $error("iteration count out of range");

    // Pen color follows the count it was loaded with
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_pen == pen_colour(16'(out_iter))))
        else $error("pen color does not match count");

endmodule

// File: verif/mand_checker.sv
// Checker for the escape-time pixel evaluator: tracks registers, predicts each pixel, compares.
`timescale 1ns / 100ps

module mand_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [23:0]                          s_tdata,    // col, row
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [47:0]                          m_tdata,    // pixel_col, pixel_row, iter_count, pen_colour
    input  logic                                 cfg_we,
    input  logic [mand_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [mand_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output int                                   fail_count,
    output int                                   pending,
    output int                                   results_seen
);
    import mand_pkg::*;

    localparam int     FRAC     = DEF_FRAC_BITS;
    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    // Same layout as m_tdata, lowest field last
    typedef struct packed {
        logic [15:0] pen;
        logic [7:0]  count;
        logic [11:0] row;
        logic [11:0] col;
    } pixel_result_t;

    pixel_result_t pending_pixels[$];

    int unsigned max_iter_q;
    int unsigned escape_q;
    longint      re_origin_q;
    longint      re_step_q;
    longint      im_origin_q;
    longint      im_step_q;

    int mismatches = 0;
    int transfers_out = 0;

    assign fail_count   = mismatches;
    assign results_seen = transfers_out;

    function automatic longint clamp_word(input longint v);
        if (v > WORD_MAX)
            return WORD_MAX;
        if (v < WORD_MIN)
            return WORD_MIN;
        return v;
    endfunction

    function automatic pixel_result_t escape_time_of(input logic [11:0] col,
                                                     input logic [11:0] row);
        longint        cx;
        longint        cy;
        longint        x;
        longint        y;
        longint        nx;
        longint        ny;
        logic [63:0]   mag;
        logic [63:0]   lim;
        int unsigned   n;
        int unsigned   pen_w;
        bit            escaped;
        pixel_result_t r;
        cx = clamp_word(re_origin_q + longint'(col) * re_step_q);
        cy = clamp_word(im_origin_q + longint'(row) * im_step_q);
        lim = 64'(escape_q) << (2 * FRAC);
        x = 0;
        y = 0;
        n = 1;
        escaped = 1'b0;
        while (n < max_iter_q && !escaped)
        begin
            // >>> on a signed value floors toward minus infinity
            nx = clamp_word(((x * x - y * y) >>> FRAC) + cx);
            ny = clamp_word(((x * y) >>> (FRAC - 1)) + cy);
            x = nx;
            y = ny;
            mag = unsigned'(x * x) + unsigned'(y * y);
            if (mag > lim)
                escaped = 1'b1;
            else
                n++;
        end
        pen_w = ((n % 256) >> 3) | ((n % 64) << 5) | (((n % 16) * 2) << 9);
        r.col   = col;
        r.row   = row;
        r.count = n[7:0];
        r.pen   = pen_w[15:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        pixel_result_t want;
        pixel_result_t got;
        if (!rst_n)
        begin
            max_iter_q  <= MAX_ITER_RST;
            escape_q    <= ESC_LIMIT_RST;
            re_origin_q <= RE_ORIGIN_RST;
            re_step_q   <= RE_STEP_RST;
            im_origin_q <= IM_ORIGIN_RST;
            im_step_q   <= IM_STEP_RST;
            pending_pixels.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_MAX_ITER:     max_iter_q  <= cfg_data[7:0];
                    REG_ESCAPE_LIMIT: escape_q    <= cfg_data[6:0];
                    REG_RE_ORIGIN:    re_origin_q <= $signed(cfg_data);
                    REG_RE_STEP:      re_step_q   <= $signed(cfg_data);
                    REG_IM_ORIGIN:    im_origin_q <= $signed(cfg_data);
                    REG_IM_STEP:      im_step_q   <= $signed(cfg_data);
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                pending_pixels.push_back(escape_time_of(s_tdata[11:0], s_tdata[23:12]));
            if (m_tvalid && m_tready)
            begin
                got = pixel_result_t'(m_tdata);
                transfers_out++;
                if (pending_pixels.size() == 0)
                begin
                    $error("result with no pixel pending: col %0d row %0d", got.col, got.row);
                    mismatches++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (got.col !== want.col)
                    begin
                        $error("pixel_col: expected %0d, got %0d", want.col, got.col);
                        mismatches++;
                    end
                    if (got.row !== want.row)
                    begin
                        $error("pixel_row: expected %0d, got %0d", want.row, got.row);
                        mismatches++;
                    end
                    if (got.count !== want.count)
                    begin
                        $error("iter_count: expected %0d, got %0d", want.count, got.count);
                        mismatches++;
                    end
                    if (got.pen !== want.pen)
                    begin
                        $error("pen_colour: expected %0d, got %0d", want.pen, got.pen);
                        mismatches++;
                    end
                end
            end
            pending <= pending_pixels.size();
        end
    end

endmodule

// File: verif/tb_top.sv
// Testbench top for the escape-time pixel evaluator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
    import mand_pkg::*;

    // Cycles with no transfer of any kind before the run is declared hung.
    // The slowest pixel is one run at max_iter 255, and output stalls can hold it longer.
    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;     // col [11:0], row [23:12]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;            // pixel_col, pixel_row, iter_count, pen_colour
    logic        cfg_we    = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;

    int fail_count;
    int pending;
    int results_seen;

    // Random idle bursts on both sides while this is set
    logic idle_on = 1'b0;
    int   stall_left = 0;
    int   quiet_cycles = 0;
    int   pixels_sent = 0;
    int   settings_used = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    mandelbrot_escape_time_pixel dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mand_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    // Result side back-pressure: m_tready drops in random bursts while idle_on is set
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 16);
        end
        else
            m_tready <= 1'b1;
    end

    // Watchdog: any transfer or register write restarts the count
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // One pixel transfer. Entered at a rising edge; valid stays high into the
    // next pixel unless a random gap is taken here.
    task automatic send_pixel(input logic [11:0] col, input logic [11:0] row);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {row, col};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pixels_sent++;
    endtask

    // Hold the input until every accepted pixel has come back. The first edge
    // lets the checker count a pixel accepted at the current edge.
    task automatic drain_pixels();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (4) @(posedge clk);
    endtask

    // Idle the block, then write all six registers back to back
    task automatic set_view(input logic [31:0] iters, input logic [31:0] limit,
                            input logic [31:0] re0, input logic [31:0] re_d,
                            input logic [31:0] im0, input logic [31:0] im_d);
        drain_pixels();
        cfg_we    <= 1'b1;
        cfg_index <= REG_MAX_ITER;
        cfg_data  <= iters;
        @(posedge clk);
        cfg_index <= REG_ESCAPE_LIMIT;
        cfg_data  <= limit;
        @(posedge clk);
        cfg_index <= REG_RE_ORIGIN;
        cfg_data  <= re0;
        @(posedge clk);
        cfg_index <= REG_RE_STEP;
        cfg_data  <= re_d;
        @(posedge clk);
        cfg_index <= REG_IM_ORIGIN;
        cfg_data  <= im0;
        @(posedge clk);
        cfg_index <= REG_IM_STEP;
        cfg_data  <= im_d;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial
    begin : stimulus
        int          phase;
        int          i;
        int          n_items;
        int          kind;
        int          iters;
        int          limit;
        int          re0;
        int          re_d;
        int          im0;
        int          im_d;
        logic [11:0] col;
        logic [11:0] row;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_on <= 1'b1;

        // Reset view: corners, the default center (inside the set) and a far point
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd320, 12'd240);
        send_pixel(12'd639, 12'd479);

        // max_iter of 0 and 1: no update runs, count stays at 1
        set_view(0, 100, RE_ORIGIN_RST, RE_STEP_RST, IM_ORIGIN_RST, IM_STEP_RST);
        send_pixel(12'd320, 12'd240);
        set_view(1, 100, RE_ORIGIN_RST, RE_STEP_RST, IM_ORIGIN_RST, IM_STEP_RST);
        send_pixel(12'd320, 12'd240);

        // c = 0 never escapes: count runs to the largest max_iter
        set_view(255, 127, 0, 0, 0, 0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);

        // Escape limit zero: z = 0 stays, any nonzero z escapes at once
        set_view(8, 0, 0, 1, 0, 0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd0);

        // Extreme origins and steps: point computation saturates both ways
        set_view(6, 127, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);

        // c just inside the limit: the update from z = c saturates x high
        set_view(10, 127, 188743680, 0, 0, 0);
        send_pixel(12'd0, 12'd0);
        // y saturates high, then low
        set_view(10, 127, 132540006, 0, 132540006, 0);
        send_pixel(12'd0, 12'd0);
        set_view(10, 127, 132540006, 0, -132540006, 0);
        send_pixel(12'd0, 12'd0);

        // Random part: views around the set or raw register contents, mostly with small max_iter
        // so that the run stays short; two phases use the largest max_iter unless drawn raw.
        for (phase = 0; phase < 16; phase++)
        begin
            kind = $urandom_range(0, 7);
            n_items = 115;
            if (phase == 5 || phase == 11)
            begin
                iters = 255;
                n_items = 20;
            end
            else if (kind < 5)
                iters = $urandom_range(2, 24);
            else
                iters = $urandom_range(25, 80);
            limit = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : 4;
            if (kind == 7)
            begin
                // Raw register contents: every bit, saturation likely
                iters = $urandom_range(0, 40);
                re0  = $urandom;
                re_d = $urandom;
                im0  = $urandom;
                im_d = $urandom;
            end
            else
            begin
                // Origin within about +-2.5, step a few thousandths
                re0  = int'($urandom_range(0, 84000000)) - 42000000;
                im0  = int'($urandom_range(0, 84000000)) - 42000000;
                re_d = $urandom_range(4096, 131072);
                im_d = $urandom_range(4096, 131072);
                if ($urandom_range(0, 1) == 1)
                    re_d = -re_d;
                if ($urandom_range(0, 1) == 1)
                    im_d = -im_d;
            end
            set_view(iters, limit, re0, re_d, im0, im_d);
            // Idle-free stretches now and then, and always in the last two phases
            idle_on <= (phase < 14) && ($urandom_range(0, 3) != 0);
            for (i = 0; i < n_items; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    col = $urandom_range(0, 4095);
                    row = $urandom_range(0, 4095);
                end
                else
                begin
                    col = $urandom_range(0, 639);
                    row = $urandom_range(0, 479);
                end
                // Sender holds off mid-phase until every pixel is back
                if (phase == 3 && i == 50)
                    drain_pixels();
                send_pixel(col, row);
            end
        end

        drain_pixels();
        repeat (100) @(posedge clk);

        $display("Sent %0d pixels over %0d register settings, %0d results compared.",
                 pixels_sent, settings_used + 1, results_seen);
        $display("Covered max_iter 0..255, escape limit 0..127, saturating points and updates.");
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
